### sv/scr_pkg.sv
`timescale 1ns / 1ps
package scr_pkg;

	localparam int RING_DEPTH = 64;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int TAG_W      = 16;
	localparam int RES_W      = 32;
	localparam int CMD_W      = 8;
	localparam int VAL_W      = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_W      = 64;

	typedef logic [IDX_W-1:0] idx_t;

	localparam logic [CMD_W-1:0] CMD_FACTORIAL = 8'h01;
	localparam logic [CMD_W-1:0] CMD_DMA_TEST  = 8'h02;

	localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_EN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DMA_ADDR  = 1'd1;

	typedef enum logic [1:0] {
		OP_SUBMIT = 2'd0,
		OP_IRQ    = 2'd1,
		OP_POLL   = 2'd2,
		OP_RESET  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		STS_OK           = 3'd0,
		STS_FULL         = 3'd1,
		STS_BAD_CMD      = 3'd2,
		STS_EMPTY        = 3'd3,
		STS_NOT_RAISED   = 3'd4,
		STS_NONE_PENDING = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		KICK_NONE = 2'd0,
		KICK_FACT = 2'd1,
		KICK_DMA  = 2'd2
	} kick_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_IRQ,
		FSM_POLL
	} fsm_t;

	typedef struct packed {
		logic set;
		idx_t set_idx;
		logic set_fact;
		logic clr;
		idx_t clr_idx;
		logic clr_all;
	} slot_ctl_t;

	typedef struct packed {
		logic any;
		idx_t idx;
		logic fact;
	} slot_hit_t;

	function automatic idx_t wrap_next(input idx_t i);
		return (i == idx_t'(RING_DEPTH - 1)) ? '0 : i + idx_t'(1);
	endfunction

endpackage

### sv/scr_if.sv
`timescale 1ns / 1ps
interface scr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] cmd_tag;
	logic [7:0]  command;
	logic [31:0] cmd_operand;
	logic        irq_raised;
	logic [31:0] device_result;

	modport source (
		output valid, opcode, cmd_tag, command, cmd_operand, irq_raised, device_result,
		input  ready
	);
	modport sink (
		input  valid, opcode, cmd_tag, command, cmd_operand, irq_raised, device_result,
		output ready
	);
endinterface

interface scr_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] done_tag;
	logic [31:0] done_result;
	logic        posted;
	logic        notify;
	logic [1:0]  kick;
	logic [63:0] kick_value;

	modport source (
		output valid, status, done_tag, done_result, posted, notify, kick, kick_value,
		input  ready
	);
	modport sink (
		input  valid, status, done_tag, done_result, posted, notify, kick, kick_value,
		output ready
	);
endinterface

### sv/scr_slot_track.sv
`timescale 1ns / 1ps
module scr_slot_track (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scr_pkg::slot_ctl_t   ctl,
	output scr_pkg::slot_hit_t   hit
);

	logic [scr_pkg::RING_DEPTH-1:0] inflight_q;
	logic [scr_pkg::RING_DEPTH-1:0] fact_q;
	logic [scr_pkg::RING_DEPTH-1:0] lowest;
	scr_pkg::idx_t                  idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			fact_q     <= '0;
		end else if (ctl.clr_all) begin
			inflight_q <= '0;
			fact_q     <= '0;
		end else begin
			if (ctl.set) begin
				inflight_q[ctl.set_idx] <= 1'b1;
				fact_q[ctl.set_idx]     <= ctl.set_fact;
			end
			if (ctl.clr) begin
				inflight_q[ctl.clr_idx] <= 1'b0;
				fact_q[ctl.clr_idx]     <= 1'b0;
			end
		end
	end

	// isolate lowest in-flight slot, then encode
	always_comb begin
		lowest = inflight_q & (~inflight_q + 1'b1);
		idx    = '0;
		for (int i = 0; i < scr_pkg::RING_DEPTH; i++) begin
			if (lowest[i])
				idx = idx | scr_pkg::idx_t'(i);
		end
	end

	assign hit.any  = |inflight_q;
	assign hit.idx  = idx;
	assign hit.fact = |(lowest & fact_q);

endmodule

### sv/submission_completion_ring_top.sv
`timescale 1ns / 1ps
// Channel | Role   | Transaction
// --------+--------+-------------------------------------------------------------
// req     | sink   | opcode, cmd_tag, command, cmd_operand, irq_raised, device_result
// rsp     | source | status, done_tag, done_result, posted, notify, kick, kick_value
// cfg     | write  | cfg_we, cfg_index, cfg_wdata (no handshake)
//
// Submit, reset and every refused operation load the response from idle; an interrupt
// that posts and a poll that dequeues register a tag or completion memory read, then
// form the result in the IRQ or POLL state. One transaction in flight at a time.
// Async reset clears pointers, in-flight marks and config; memories are not cleared.
// req is taken in the idle state while the response register is empty or being drained.
module submission_completion_ring_top (
	input  logic                            clk,
	input  logic                            arst_n,
	scr_req_if.sink                         req,
	scr_rsp_if.source                       rsp,
	input  logic                            cfg_we,
	input  logic [scr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [scr_pkg::CFG_W-1:0]       cfg_wdata
);

	localparam int CMPL_W = scr_pkg::TAG_W + scr_pkg::RES_W;

	scr_pkg::fsm_t       state_q, state_d;
	scr_pkg::idx_t       sub_tail_q, sub_tail_d;
	scr_pkg::idx_t       cmpl_tail_q, cmpl_tail_d;
	scr_pkg::idx_t       cmpl_head_q, cmpl_head_d;
	logic                notify_en_q;
	logic [scr_pkg::VAL_W-1:0] dma_addr_q;

	scr_pkg::slot_ctl_t  slot_ctl;
	scr_pkg::slot_hit_t  hit;

	logic [scr_pkg::TAG_W-1:0] tags_mem [scr_pkg::RING_DEPTH];
	logic [CMPL_W-1:0]         cmpl_mem [scr_pkg::RING_DEPTH];
	logic [scr_pkg::TAG_W-1:0] tag_rd_s1;
	logic [CMPL_W-1:0]         cmpl_rd_s1;
	logic                      tags_we;
	logic                      cmpl_we;
	logic                      cmpl_re;
	logic [CMPL_W-1:0]         cmpl_wdata;

	scr_pkg::idx_t             irq_idx_q;
	logic                      irq_fact_q;
	logic [scr_pkg::RES_W-1:0] dev_res_q;
	logic                      irq_ld;

	logic                      accept;
	logic                      out_load;
	logic                      rsp_valid_q;

	scr_pkg::status_t          o_status, status_q;
	logic [scr_pkg::TAG_W-1:0] o_done_tag, done_tag_q;
	logic [scr_pkg::RES_W-1:0] o_done_result, done_result_q;
	logic                      o_posted, posted_q;
	logic                      o_notify, notify_q;
	scr_pkg::kick_t            o_kick, kick_q;
	logic [scr_pkg::VAL_W-1:0] o_kick_value, kick_value_q;

	scr_slot_track u_slot (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (slot_ctl),
		.hit    (hit)
	);

	assign req.ready = (state_q == scr_pkg::FSM_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign cmpl_wdata = {tag_rd_s1, irq_fact_q ? dev_res_q : {scr_pkg::RES_W{1'b0}}};

	always_comb begin
		state_d       = state_q;
		sub_tail_d    = sub_tail_q;
		cmpl_tail_d   = cmpl_tail_q;
		cmpl_head_d   = cmpl_head_q;
		slot_ctl      = '0;
		tags_we       = 1'b0;
		cmpl_we       = 1'b0;
		cmpl_re       = 1'b0;
		irq_ld        = 1'b0;
		out_load      = 1'b0;
		o_status      = scr_pkg::STS_OK;
		o_done_tag    = '0;
		o_done_result = '0;
		o_posted      = 1'b0;
		o_notify      = 1'b0;
		o_kick        = scr_pkg::KICK_NONE;
		o_kick_value  = '0;
		case (state_q)
			scr_pkg::FSM_IDLE: begin
				if (accept) begin
					case (scr_pkg::opcode_t'(req.opcode))
						scr_pkg::OP_SUBMIT: begin
							out_load = 1'b1;
							if (scr_pkg::wrap_next(sub_tail_q) == cmpl_head_q) begin
								o_status = scr_pkg::STS_FULL;
							end else begin
								tags_we    = 1'b1;
								sub_tail_d = scr_pkg::wrap_next(sub_tail_q);
								if (req.command != '0) begin
									slot_ctl.set      = 1'b1;
									slot_ctl.set_idx  = sub_tail_q;
									slot_ctl.set_fact = (req.command == scr_pkg::CMD_FACTORIAL);
								end else begin
									slot_ctl.clr     = 1'b1;
									slot_ctl.clr_idx = sub_tail_q;
								end
								if (req.command == scr_pkg::CMD_FACTORIAL) begin
									o_kick       = scr_pkg::KICK_FACT;
									o_kick_value = {{(scr_pkg::VAL_W - scr_pkg::RES_W){1'b0}},
										req.cmd_operand};
								end else if (req.command == scr_pkg::CMD_DMA_TEST) begin
									o_kick       = scr_pkg::KICK_DMA;
									o_kick_value = dma_addr_q;
								end else begin
									o_status = scr_pkg::STS_BAD_CMD;
								end
							end
						end
						scr_pkg::OP_IRQ: begin
							if (!req.irq_raised) begin
								out_load = 1'b1;
								o_status = scr_pkg::STS_NOT_RAISED;
							end else if (!hit.any) begin
								out_load = 1'b1;
								o_status = scr_pkg::STS_NONE_PENDING;
							end else begin
								irq_ld  = 1'b1;
								state_d = scr_pkg::FSM_IRQ;
							end
						end
						scr_pkg::OP_POLL: begin
							if (cmpl_head_q == cmpl_tail_q) begin
								out_load = 1'b1;
								o_status = scr_pkg::STS_EMPTY;
							end else begin
								cmpl_re = 1'b1;
								state_d = scr_pkg::FSM_POLL;
							end
						end
						scr_pkg::OP_RESET: begin
							out_load         = 1'b1;
							slot_ctl.clr_all = 1'b1;
							sub_tail_d       = '0;
							cmpl_tail_d      = '0;
							cmpl_head_d      = '0;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			scr_pkg::FSM_IRQ: begin
				cmpl_we          = 1'b1;
				cmpl_tail_d      = scr_pkg::wrap_next(cmpl_tail_q);
				slot_ctl.clr     = 1'b1;
				slot_ctl.clr_idx = irq_idx_q;
				out_load         = 1'b1;
				o_posted         = 1'b1;
				o_notify         = notify_en_q;
				state_d          = scr_pkg::FSM_IDLE;
			end
			scr_pkg::FSM_POLL: begin
				out_load      = 1'b1;
				o_done_tag    = cmpl_rd_s1[CMPL_W-1:scr_pkg::RES_W];
				o_done_result = cmpl_rd_s1[scr_pkg::RES_W-1:0];
				cmpl_head_d   = scr_pkg::wrap_next(cmpl_head_q);
				state_d       = scr_pkg::FSM_IDLE;
			end
			default: begin
				state_d = scr_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scr_pkg::FSM_IDLE;
			sub_tail_q  <= '0;
			cmpl_tail_q <= '0;
			cmpl_head_q <= '0;
			rsp_valid_q <= 1'b0;
			notify_en_q <= 1'b0;
			dma_addr_q  <= '0;
		end else begin
			state_q     <= state_d;
			sub_tail_q  <= sub_tail_d;
			cmpl_tail_q <= cmpl_tail_d;
			cmpl_head_q <= cmpl_head_d;
			if (out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					scr_pkg::CFG_NOTIFY_EN: notify_en_q <= cfg_wdata[0];
					scr_pkg::CFG_DMA_ADDR:  dma_addr_q  <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q      <= o_status;
			done_tag_q    <= o_done_tag;
			done_result_q <= o_done_result;
			posted_q      <= o_posted;
			notify_q      <= o_notify;
			kick_q        <= o_kick;
			kick_value_q  <= o_kick_value;
		end
		if (irq_ld) begin
			irq_idx_q  <= hit.idx;
			irq_fact_q <= hit.fact;
			dev_res_q  <= req.device_result;
		end
	end

	always_ff @(posedge clk) begin
		if (tags_we)
			tags_mem[sub_tail_q] <= req.cmd_tag;
		if (irq_ld)
			tag_rd_s1 <= tags_mem[hit.idx];
	end

	always_ff @(posedge clk) begin
		if (cmpl_we)
			cmpl_mem[cmpl_tail_q] <= cmpl_wdata;
		if (cmpl_re)
			cmpl_rd_s1 <= cmpl_mem[cmpl_head_q];
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.done_tag    = done_tag_q;
	assign rsp.done_result = done_result_q;
	assign rsp.posted      = posted_q;
	assign rsp.notify      = notify_q;
	assign rsp.kick        = kick_q;
	assign rsp.kick_value  = kick_value_q;

endmodule
